// ----- hdl/dpr_pkg.sv -----
// types, constants and helpers for the parabolic dac ramp generator
// no dependencies; imported by dpr_step, dac_parabolic_ramp and the testbench
package dpr_pkg;

  localparam int DAC_BITS  = 16;
  localparam int FRAC_BITS = 5;
  localparam int CH_BITS   = 3;
  localparam int NUM_CH    = 1 << CH_BITS;
  localparam int ACC_BITS  = 16;
  localparam int FINE_BITS = DAC_BITS + FRAC_BITS;
  localparam int POS_BITS  = FINE_BITS + 3;
  localparam int SPD_BITS  = FINE_BITS + 2;
  localparam int WIDE_BITS = POS_BITS + 2;

  localparam logic [DAC_BITS-1:0] DAC_MAX = {DAC_BITS{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2,
    PH_LAST = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [POS_BITS-1:0]   pos;
    logic [SPD_BITS-1:0]   speed;
    logic [DAC_BITS-1:0]   next_code;
    logic [DAC_BITS-1:0]   goal_code;
    logic [FINE_BITS-1:0]  mid_fine;
    logic                  going_up;
    logic                  steady;
    logic [CH_BITS-1:0]    busy_chan;
  } ramp_state_t;

  typedef struct packed {
    logic                  valid;
    logic [CH_BITS-1:0]    chan;
    logic [DAC_BITS-1:0]   code;
    logic                  done;
  } ramp_res_t;

  // fine position to dac code, clamped at both ends
  function automatic logic [DAC_BITS-1:0] code_of(input logic [POS_BITS-1:0] fine);
    logic [POS_BITS-FRAC_BITS-1:0] c;
    c = fine[POS_BITS-1:FRAC_BITS];
    if (fine[POS_BITS-1]) begin
      return '0;
    end else if (c > (POS_BITS-FRAC_BITS)'(DAC_MAX)) begin
      return DAC_MAX;
    end else begin
      return c[DAC_BITS-1:0];
    end
  endfunction

endpackage

// ----- hdl/dpr_step.sv -----
// next-state and result logic for one request of the ramp generator
// depends on dpr_pkg
module dpr_step (
  input  dpr_pkg::ramp_state_t          st,
  input  logic                          kind,
  input  logic [dpr_pkg::CH_BITS-1:0]   chan,
  input  logic [dpr_pkg::DAC_BITS-1:0]  goal,
  input  logic                          profile,
  input  logic [dpr_pkg::DAC_BITS-1:0]  cur,
  input  logic [dpr_pkg::ACC_BITS-1:0]  acc,
  output dpr_pkg::ramp_state_t          st_next,
  output dpr_pkg::ramp_res_t            res
);
  import dpr_pkg::*;

  localparam int W = WIDE_BITS;

  logic signed [W-1:0] g_w, spd_w, pos_w, goal_w, mid_w, aim_w;
  logic signed [W-1:0] rise_spd, fall_d, fall_spd, step_spd, pos_new;
  logic                go, chan_ok;
  logic [DAC_BITS:0]   mid_sum;

  assign g_w    = $signed(W'(acc));
  assign spd_w  = $signed(W'(st.speed));
  assign pos_w  = W'($signed(st.pos));
  assign goal_w = $signed(W'({st.goal_code, {FRAC_BITS{1'b0}}}));
  assign mid_w  = $signed(W'(st.mid_fine));

  assign rise_spd = spd_w + g_w;
  assign fall_d   = spd_w - g_w;
  // slowing down never lets the speed drop below one increment
  assign fall_spd = (fall_d > g_w) ? fall_d : g_w;
  assign step_spd = (st.phase == PH_RISE) ? rise_spd : fall_spd;
  assign aim_w    = (st.phase == PH_RISE && st.steady) ? mid_w : goal_w;

  assign go      = st.going_up ? (pos_w <= aim_w - step_spd) : (pos_w >= aim_w + step_spd);
  assign pos_new = st.going_up ? (pos_w + step_spd) : (pos_w - step_spd);

  assign chan_ok = (CH_BITS+1)'(chan) < (CH_BITS+1)'(NUM_CH);
  assign mid_sum = (DAC_BITS+1)'(cur) + (DAC_BITS+1)'(goal);

  always_comb begin
    st_next   = st;
    res       = '0;
    res.chan  = st.busy_chan;
    if (kind) begin
      if (st.phase == PH_IDLE && chan_ok) begin
        st_next.busy_chan = chan;
        st_next.goal_code = goal;
        st_next.steady    = profile;
        st_next.going_up  = cur < goal;
        st_next.pos       = POS_BITS'({cur, {FRAC_BITS{1'b0}}});
        st_next.speed     = '0;
        st_next.next_code = cur;
        st_next.mid_fine  = {mid_sum[DAC_BITS:1], {FRAC_BITS{1'b0}}};
        st_next.phase     = PH_RISE;
      end
    end else if (st.phase != PH_IDLE) begin
      res.valid = 1'b1;
      case (st.phase)
        PH_LAST: begin
          res.code      = st.goal_code;
          res.done      = 1'b1;
          st_next.phase = PH_IDLE;
        end
        PH_RISE, PH_FALL: begin
          res.code          = st.next_code;
          st_next.speed     = step_spd[SPD_BITS-1:0];
          st_next.pos       = pos_new[POS_BITS-1:0];
          st_next.next_code = code_of(pos_new[POS_BITS-1:0]);
          if (!go) begin
            if (st.phase == PH_RISE && st.steady) begin
              // overshoot code stays queued, position snaps to the midpoint
              st_next.pos   = POS_BITS'(st.mid_fine);
              st_next.phase = PH_FALL;
            end else begin
              st_next.phase = PH_LAST;
            end
          end
        end
        default: begin
          st_next.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/dac_parabolic_ramp.sv -----
// parabolic ramp generator: per-channel last codes in a ram with a registered read,
// the move registers and a registered result; depends on dpr_pkg and dpr_step
// a tick request passes the s1 registers, then the result registers; the ram read of
// a start overlaps the previous request; one request per cycle unless the output stalls
// reset: move idle, accel 1, every channel's last code reads as zero until written
module dac_parabolic_ramp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dpr_pkg::ACC_BITS-1:0]  accel,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [dpr_pkg::CH_BITS-1:0]   chan,
  input  logic [dpr_pkg::DAC_BITS-1:0]  goal,
  input  logic                          profile,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dpr_pkg::CH_BITS-1:0]   out_chan,
  output logic [dpr_pkg::DAC_BITS-1:0]  dac_code,
  output logic                          move_done
);
  import dpr_pkg::*;

  logic [ACC_BITS-1:0] acc_reg, acc_eff;

  logic                s1_valid, s1_kind, s1_profile, s1_fire, in_acc;
  logic [CH_BITS-1:0]  s1_chan;
  logic [DAC_BITS-1:0] s1_goal;

  logic [DAC_BITS-1:0] mem [NUM_CH];
  logic [NUM_CH-1:0]   mem_vld;
  logic [DAC_BITS-1:0] rd_q, fwd_data, cur;
  logic                rd_vld, rd_fwd, wr_en, fwd_hit;

  ramp_state_t st, st_next;
  ramp_res_t   res;

  assign cfg_ready = 1'b1;
  assign acc_eff   = (acc_reg == '0) ? ACC_BITS'(1) : acc_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_reg <= ACC_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      acc_reg <= accel;
    end
  end

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind    <= kind;
      s1_chan    <= chan;
      s1_goal    <= goal;
      s1_profile <= profile;
    end
  end

  // last-code ram, written by each emitted code
  assign wr_en   = s1_fire && res.valid;
  assign fwd_hit = wr_en && (st.busy_chan == chan);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[st.busy_chan] <= res.code;
    end
    if (in_acc) begin
      rd_q     <= mem[chan];
      fwd_data <= res.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rd_vld  <= 1'b0;
      rd_fwd  <= 1'b0;
    end else begin
      if (wr_en) begin
        mem_vld[st.busy_chan] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld <= mem_vld[chan] || fwd_hit;
        rd_fwd <= fwd_hit;
      end
    end
  end

  // same-channel write in the read cycle is forwarded
  assign cur = !rd_vld ? '0 : (rd_fwd ? fwd_data : rd_q);

  dpr_step u_step (
    .st      (st),
    .kind    (s1_kind),
    .chan    (s1_chan),
    .goal    (s1_goal),
    .profile (s1_profile),
    .cur     (cur),
    .acc     (acc_eff),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_chan  <= res.chan;
      dac_code  <= res.code;
      move_done <= res.done;
    end
  end

  a_idle_tick_silent: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_kind && st.phase == PH_IDLE |=> !out_valid)
    else $error("tick while idle produced a result");

  a_fall_steady: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_FALL |-> st.steady)
    else $error("deceleration phase outside steady profile");

  a_wr_marks_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> mem_vld[$past(st.busy_chan)])
    else $error("ram entry not marked valid after write");

  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire))
    else $error("result appeared without a processed request");

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for dac_parabolic_ramp: directed moves, a full stall
// of the result side and random move sequences over several accel settings
// depends on dpr_pkg and the rtl of dac_parabolic_ramp
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dpr_pkg::*;

  localparam int     ITEMS        = 1500;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_CYCLES = 4;
  localparam int     STALL_LIMIT  = 4000;
  localparam longint FINE_ONE     = longint'(1) << FRAC_BITS;

  typedef struct {
    logic [CH_BITS-1:0]  chan;
    logic [DAC_BITS-1:0] code;
    logic                done;
  } dac_write_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ACC_BITS-1:0] accel     = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic                kind      = 1'b0;
  logic [CH_BITS-1:0]  chan      = '0;
  logic [DAC_BITS-1:0] goal      = '0;
  logic                profile   = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CH_BITS-1:0]  out_chan;
  logic [DAC_BITS-1:0] dac_code;
  logic                move_done;

  // own copy of the ramp state, updated on every accepted request
  logic [ACC_BITS-1:0] accel_cfg = 16'd1;
  logic [DAC_BITS-1:0] chan_code [NUM_CH] = '{default: '0};
  longint              pos_fine  = 0;
  longint              speed     = 0;
  longint              mid_fine  = 0;
  logic [DAC_BITS-1:0] next_code = '0;
  logic [DAC_BITS-1:0] goal_code = '0;
  bit                  going_up  = 1'b0;
  bit                  steady    = 1'b0;
  logic [CH_BITS-1:0]  busy_chan = '0;
  phase_t              ramp_phase = PH_IDLE;

  dac_write_t pending_codes [$];
  int         err_count  = 0;
  int         item_count = 0;
  bit         no_gaps    = 1'b0;
  bit         no_stall   = 1'b0;
  bit         hold_off   = 1'b0;

  dac_parabolic_ramp i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .accel     (accel),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .chan      (chan),
    .goal      (goal),
    .profile   (profile),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_chan  (out_chan),
    .dac_code  (dac_code),
    .move_done (move_done)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one step of the position towards aim, clamps the code; 0 once the aim would be passed
  function automatic bit step_towards(input longint aim);
    bit     go;
    longint c;
    if (going_up) begin
      go = pos_fine <= aim - speed;
      pos_fine += speed;
    end else begin
      go = pos_fine >= aim + speed;
      pos_fine -= speed;
    end
    c = pos_fine >>> FRAC_BITS;
    if (pos_fine < 0) next_code = '0;
    else if (c > longint'(DAC_MAX)) next_code = DAC_MAX;
    else next_code = c[DAC_BITS-1:0];
    return go;
  endfunction

  task automatic track_ramp(input logic k, input logic [CH_BITS-1:0] c,
                            input logic [DAC_BITS-1:0] g, input logic p);
    longint              step;
    longint              goal_fine;
    logic [DAC_BITS-1:0] cur;
    logic [DAC_BITS-1:0] code;
    dac_write_t          w;
    bit                  go;
    step = (accel_cfg == '0) ? longint'(1) : longint'(accel_cfg);
    if (k) begin
      // a start while a move runs is dropped
      if (ramp_phase != PH_IDLE) return;
      cur        = chan_code[c];
      busy_chan  = c;
      goal_code  = g;
      steady     = p;
      going_up   = cur < g;
      pos_fine   = longint'(cur) * FINE_ONE;
      speed      = 0;
      next_code  = cur;
      mid_fine   = longint'(({1'b0, cur} + {1'b0, g}) >> 1) * FINE_ONE;
      ramp_phase = PH_RISE;
      return;
    end
    if (ramp_phase == PH_IDLE) return;
    w.chan = busy_chan;
    w.done = 1'b0;
    if (ramp_phase == PH_LAST) begin
      code       = goal_code;
      w.done     = 1'b1;
      ramp_phase = PH_IDLE;
    end else begin
      code      = next_code;
      goal_fine = longint'(goal_code) * FINE_ONE;
      if (ramp_phase == PH_RISE) begin
        speed += step;
        go = step_towards(steady ? mid_fine : goal_fine);
        if (!go) begin
          if (steady) begin
            pos_fine   = mid_fine;
            ramp_phase = PH_FALL;
          end else begin
            ramp_phase = PH_LAST;
          end
        end
      end else begin
        speed = (speed - step > step) ? speed - step : step;
        if (!step_towards(goal_fine)) ramp_phase = PH_LAST;
      end
    end
    chan_code[busy_chan] = code;
    w.code = code;
    pending_codes.push_back(w);
  endtask

  task automatic send_request(input logic k, input logic [CH_BITS-1:0] c,
                              input logic [DAC_BITS-1:0] g, input logic p);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind     <= k;
    chan     <= c;
    goal     <= g;
    profile  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_ramp(k, c, g, p);
  endtask

  // tick with junk in the fields that a tick does not use
  task automatic send_tick();
    send_request(1'b0, CH_BITS'($urandom), DAC_BITS'($urandom), 1'($urandom));
  endtask

  task automatic finish_move();
    while (ramp_phase != PH_IDLE) send_tick();
  endtask

  task automatic run_move(input logic [CH_BITS-1:0] c, input logic [DAC_BITS-1:0] g,
                          input logic p, input bit stray_ok);
    send_request(1'b1, c, g, p);
    item_count++;
    while (ramp_phase != PH_IDLE) begin
      if (stray_ok && $urandom_range(0, 39) == 0) begin
        send_request(1'b1, CH_BITS'($urandom), DAC_BITS'($urandom), 1'($urandom));
      end else begin
        send_tick();
        item_count++;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_accel(input logic [ACC_BITS-1:0] v);
    finish_move();
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    accel     <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    accel_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_tick();                         // tick with no move running
    run_move(3'd0, 16'd0, 1'b0, 1'b0);   // start equals target
    write_accel(16'hFFFF);
    run_move(3'd7, 16'hFFFF, 1'b0, 1'b0);
    run_move(3'd7, 16'd0, 1'b1, 1'b0);
    // overshoot past the top of the range
    run_move(3'd2, 16'hFFFE, 1'b0, 1'b0);
    run_move(3'd2, 16'hFFFF, 1'b1, 1'b0);
    // overshoot below zero, then past a goal just above
    run_move(3'd3, 16'd1, 1'b0, 1'b0);
    run_move(3'd3, 16'd0, 1'b1, 1'b0);
    run_move(3'd3, 16'd1, 1'b1, 1'b0);
    // start request while busy is dropped
    send_request(1'b1, 3'd4, 16'd40000, 1'b1);
    send_tick();
    send_request(1'b1, 3'd5, 16'd9, 1'b0);
    finish_move();
    write_accel(16'd0);
    run_move(3'd6, 16'd2, 1'b1, 1'b0);
  endtask

  task automatic test_full_backpressure();
    write_accel(16'd2000);
    hold_off = 1'b1;
    run_move(3'd5, 16'd60000, 1'b0, 1'b0);
    while (hold_off) @(posedge clk);
    run_move(3'd5, 16'd100, 1'b1, 1'b0);
  endtask

  task automatic test_random_moves();
    int                  r;
    int                  d;
    int                  v;
    int                  first;
    bit                  near_only;
    logic [ACC_BITS-1:0] a;
    logic [CH_BITS-1:0]  c;
    logic [DAC_BITS-1:0] g;
    first = item_count;
    while (item_count - first < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) a = 16'd1;
      else if (r < 20) a = 16'hFFFF;
      else if (r < 25) a = 16'd0;
      else if (r < 60) a = ACC_BITS'($urandom_range(2, 63));
      else a = ACC_BITS'($urandom_range(64, 65534));
      // small accel makes long moves, so keep those short
      near_only = a < 64;
      write_accel(a);
      no_gaps  = ($urandom_range(0, 3) == 0);
      no_stall = no_gaps;
      repeat ($urandom_range(2, 8)) begin
        c = CH_BITS'($urandom);
        r = $urandom_range(0, 99);
        if (r < 5) begin
          g = chan_code[c];
        end else if (!near_only && r < 10) begin
          g = (r < 8) ? DAC_MAX : '0;
        end else if (!near_only && r < 55) begin
          g = DAC_BITS'($urandom);
        end else begin
          d = $urandom_range(0, 600) - 300;
          v = int'(chan_code[c]) + d;
          g = (v < 0) ? '0 : (v > 65535) ? DAC_MAX : DAC_BITS'(v);
        end
        r = $urandom_range(0, 99);
        if (r < 4) send_tick();
        else if (r < 8) begin
          // move broken off, the next start is dropped and the old one runs out
          send_request(1'b1, c, g, 1'($urandom));
          repeat ($urandom_range(1, 4)) send_tick();
        end
        run_move(c, g, 1'($urandom), 1'b1);
      end
      no_gaps  = 1'b0;
      no_stall = 1'b0;
    end
  endtask

  initial begin : receiver
    int stall_left;
    int held;
    stall_left = 0;
    held       = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) begin
          held     = 0;
          hold_off = 1'b0;
        end
      end else if (no_stall) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        if (stall_left == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left--;
        end
      end
    end
  end

  always @(posedge clk) begin : check_result
    dac_write_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        $error("result with no request pending: out_chan %0d dac_code %0d move_done %0b",
               out_chan, dac_code, move_done);
        err_count++;
      end else begin
        want = pending_codes.pop_front();
        if (out_chan !== want.chan) begin
          $error("out_chan: expected %0d, got %0d", want.chan, out_chan);
          err_count++;
        end
        if (dac_code !== want.code) begin
          $error("dac_code: expected %0d, got %0d", want.code, dac_code);
          err_count++;
        end
        if (move_done !== want.done) begin
          $error("move_done: expected %0b, got %0b", want.done, move_done);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_full_backpressure();
    test_random_moves();
    wait_idle();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
